// ===== rtl/kht_pkg.sv =====
package kht_pkg;

  localparam int MAX_KEYS_DEF = 64;

  // register indexes on the configuration port
  localparam logic REG_NUM_KEYS = 1'b0;

  // item kinds carried in s_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // squared distance limit for the nearest-center fallback (5000 squared)
  localparam logic [33:0] NEAR_LIMIT_SQ = 34'd25000000;

  typedef struct packed {
    logic [11:0]        h;
    logic [11:0]        w;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } kht_key_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  hit;
    logic        in_rect;
  } kht_result_t;

endpackage

// ===== rtl/key_hit_test_nearest.sv =====
// Key hit test with nearest-center fallback. Write beats (s_tuser = 0) store one key
// rectangle into a table slot and return nothing; writes to slots at or
// beyond MAX_KEYS are dropped. A query beat (s_tuser = 1) scans slots 0..min(num_keys,
// MAX_KEYS)-1 out of the key table memory, one slot per cycle through a four-stage
// read/distance/square/compare pipeline, and returns one result beat; the input reopens
// before that beat shows on the output. The first rectangle containing the point (edges
// included) wins, otherwise the strictly nearest center within 5000 pixels, lowest index
// on ties. Only one query is in flight; a finished result waits in the output register
// while new beats are accepted. Slots must be written before a query scans them; the
// table is not cleared by reset.
module key_hit_test_nearest #(
  parameter int MAX_KEYS = kht_pkg::MAX_KEYS_DEF,
  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // entry_index[5:0], point_x[21:6], point_y[37:22], rect_width[49:38],
  // rect_height[61:50], zero[63:62]
  input  logic [63:0] s_tdata,
  // opcode[0]
  input  logic        s_tuser,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // hit_index[5:0], zero[7:6]
  output logic [7:0]  m_tdata,
  // found[0], inside_res[1]
  output logic [1:0]  m_tuser
);

  logic [6:0]           num_keys;
  logic                 cfg_wr;
  logic                 in_beat;
  logic                 tbl_we;
  logic [AW-1:0]        raddr;
  kht_pkg::kht_key_t    wdata;
  kht_pkg::kht_key_t    rdata;
  logic                 busy;
  logic                 res_valid;
  kht_pkg::kht_result_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == kht_pkg::REG_NUM_KEYS) ? {25'b0, num_keys} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_keys <= 7'd0;
    end else if (cfg_wr && paddr[2] == kht_pkg::REG_NUM_KEYS) begin
      num_keys <= pwdata[6:0];
    end
  end

  assign s_tready = !busy;
  assign in_beat  = s_tvalid && s_tready;

  assign wdata.x = s_tdata[21:6];
  assign wdata.y = s_tdata[37:22];
  assign wdata.w = s_tdata[49:38];
  assign wdata.h = s_tdata[61:50];
  assign tbl_we  = in_beat && (s_tuser == kht_pkg::OP_WRITE) &&
                   (32'(s_tdata[5:0]) < MAX_KEYS);

  kht_table #(.MAX_KEYS(MAX_KEYS)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(s_tdata[5:0])),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  kht_scan #(.MAX_KEYS(MAX_KEYS)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (in_beat && (s_tuser == kht_pkg::OP_QUERY)),
    .start_x   (s_tdata[21:6]),
    .start_y   (s_tdata[37:22]),
    .num_keys  (num_keys),
    .busy      (busy),
    .raddr     (raddr),
    .rdata     (rdata),
    .res_free  (!m_tvalid || m_tready),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {2'b0, res.hit};
      m_tuser <= {res.in_rect, res.found};
    end
  end

endmodule

// ===== rtl/kht_table.sv =====
module kht_table #(
  parameter int MAX_KEYS = kht_pkg::MAX_KEYS_DEF,
  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  kht_pkg::kht_key_t wdata,
  input  logic [AW-1:0]    raddr,
  output kht_pkg::kht_key_t rdata
);

  kht_pkg::kht_key_t mem [MAX_KEYS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/kht_scan.sv =====
module kht_scan #(
  parameter int MAX_KEYS = kht_pkg::MAX_KEYS_DEF,
  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
  localparam int CW = $clog2(MAX_KEYS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [15:0]   start_x,
  input  logic signed [15:0]   start_y,
  input  logic [6:0]           num_keys,
  output logic                 busy,
  output logic [AW-1:0]        raddr,
  input  kht_pkg::kht_key_t    rdata,
  input  logic                 res_free,
  output logic                 res_valid,
  output kht_pkg::kht_result_t res
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;

  logic signed [15:0] px;
  logic signed [15:0] py;
  logic [CW-1:0]      n;
  logic [CW-1:0]      icnt;
  logic               rd_en;

  // pipeline: v1 read data, v2 distances, v3 squares
  logic          v1, v2, v3;
  logic [AW-1:0] idx1, idx2, idx3;
  logic [16:0]   dx, dy;
  logic          in2, in3;
  logic [33:0]   sqx, sqy;
  logic [33:0]   dist_sq;

  logic [33:0]   best;
  logic          ins_found, near_found;
  logic [AW-1:0] ins_hit, near_hit;

  logic signed [17:0] cx, cy, ddx, ddy, rx, ry, px18, py18;
  logic               in_now;
  logic [CW-1:0]      n_next;

  assign rd_en = (state == S_RUN) && (icnt < n);
  assign raddr = icnt[AW-1:0];
  assign busy  = (state != S_IDLE);

  always_comb begin
    if (32'(num_keys) < MAX_KEYS) begin
      n_next = CW'(num_keys);
    end else begin
      n_next = CW'(MAX_KEYS);
    end
  end

  // geometry of the entry just read
  always_comb begin
    px18   = 18'(px);
    py18   = 18'(py);
    cx     = 18'(rdata.x) + $signed({7'b0, rdata.w[11:1]});
    cy     = 18'(rdata.y) + $signed({7'b0, rdata.h[11:1]});
    rx     = 18'(rdata.x) + $signed({6'b0, rdata.w});
    ry     = 18'(rdata.y) + $signed({6'b0, rdata.h});
    ddx    = px18 - cx;
    ddy    = py18 - cy;
    in_now = (px18 >= 18'(rdata.x)) && (px18 <= rx) &&
             (py18 >= 18'(rdata.y)) && (py18 <= ry);
  end

  assign dist_sq = sqx + sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      ins_found  <= 1'b0;
      near_found <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      v1        <= rd_en;
      v2        <= v1;
      v3        <= v2;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            ins_found  <= 1'b0;
            near_found <= 1'b0;
            state      <= S_RUN;
          end
        end
        S_RUN: begin
          if (v3) begin
            if (in3 && !ins_found) begin
              ins_found <= 1'b1;
            end
            if (dist_sq < best) begin
              near_found <= 1'b1;
            end
          end
          if (!rd_en && !v1 && !v2 && !v3) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_free) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      px   <= start_x;
      py   <= start_y;
      n    <= n_next;
      icnt <= '0;
      best <= kht_pkg::NEAR_LIMIT_SQ;
    end
    if (rd_en) begin
      icnt <= icnt + CW'(1);
    end
    idx1 <= raddr;
    idx2 <= idx1;
    idx3 <= idx2;
    dx   <= ddx[17] ? 17'(-ddx) : 17'(ddx);
    dy   <= ddy[17] ? 17'(-ddy) : 17'(ddy);
    in2  <= in_now;
    in3  <= in2;
    sqx  <= 34'(dx) * 34'(dx);
    sqy  <= 34'(dy) * 34'(dy);
    if (state == S_RUN && v3) begin
      if (in3 && !ins_found) begin
        ins_hit <= idx3;
      end
      if (dist_sq < best) begin
        best     <= dist_sq;
        near_hit <= idx3;
      end
    end
    if (state == S_DONE && res_free) begin
      res.found   <= ins_found || near_found;
      res.in_rect <= ins_found;
      if (ins_found) begin
        res.hit <= 6'(ins_hit);
      end else if (near_found) begin
        res.hit <= 6'(near_hit);
      end else begin
        res.hit <= 6'd0;
      end
    end
  end

endmodule

// ===== rtl/kht_checker.sv =====
module kht_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser
);

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // inside hit is always a found key, and a miss reports index zero
  a_result_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((!m_tuser[1] || m_tuser[0]) && (m_tuser[0] || m_tdata == 8'd0)))
    else $error("inconsistent result code");

  // a write beat never causes a result; the cycle the input reopens after a
  // query may still hand that query's result to the output
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == kht_pkg::OP_WRITE && !m_tvalid && $past(s_tready))
    |=> !m_tvalid)
    else $error("result after write beat");

  // a query keeps the input closed while it scans
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == kht_pkg::OP_QUERY) |=> !s_tready)
    else $error("input open during scan");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind key_hit_test_nearest kht_checker u_kht_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/sv/key_hit_test_nearest_test.sv =====
module key_hit_test_nearest_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_NUM_KEYS = {kht_pkg::REG_NUM_KEYS, 2'b00};
  // no register decodes here
  localparam logic [2:0] ADDR_SPARE = 3'd4;
  localparam int SETTLE_CYCLES = 80;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 228;

  // mirror of the key table, and the hit results still owed by the block
  class hit_scoreboard;
    kht_pkg::kht_key_t keys [kht_pkg::MAX_KEYS_DEF];
    int unsigned num_keys;
    kht_pkg::kht_result_t hits_due [$];
    int errors;

    function kht_pkg::kht_result_t nearest_hit(int px, int py);
      kht_pkg::kht_result_t r;
      int n;
      int cx;
      int cy;
      longint dx;
      longint dy;
      longint d2;
      longint best;
      r = '0;
      n = (num_keys < kht_pkg::MAX_KEYS_DEF) ? num_keys : kht_pkg::MAX_KEYS_DEF;
      for (int i = 0; i < n; i++) begin
        if (!r.found && px >= int'(keys[i].x) && px <= int'(keys[i].x) + int'(keys[i].w) &&
            py >= int'(keys[i].y) && py <= int'(keys[i].y) + int'(keys[i].h)) begin
          r.found = 1'b1;
          r.in_rect = 1'b1;
          r.hit = 6'(i);
        end
      end
      if (!r.found) begin
        best = longint'(kht_pkg::NEAR_LIMIT_SQ);
        for (int i = 0; i < n; i++) begin
          cx = int'(keys[i].x) + int'(keys[i].w >> 1);
          cy = int'(keys[i].y) + int'(keys[i].h >> 1);
          dx = px - cx;
          dy = py - cy;
          d2 = dx * dx + dy * dy;
          // strict compare keeps the lowest index on ties
          if (d2 < best) begin
            best = d2;
            r.found = 1'b1;
            r.hit = 6'(i);
          end
        end
      end
      return r;
    endfunction

    function void note_beat(logic op, logic [63:0] data);
      kht_pkg::kht_key_t k;
      k.x = data[21:6];
      k.y = data[37:22];
      k.w = data[49:38];
      k.h = data[61:50];
      if (op == kht_pkg::OP_WRITE) begin
        keys[data[5:0]] = k;
      end else begin
        hits_due.push_back(nearest_hit(int'(k.x), int'(k.y)));
      end
    endfunction

    function void check_result(logic [7:0] tdata, logic [1:0] tuser);
      kht_pkg::kht_result_t want;
      if (hits_due.size() == 0) begin
        $display("%0t: unexpected result found=%0b hit=%0d inside=%0b", $realtime,
                 tuser[0], tdata[5:0], tuser[1]);
        errors++;
        return;
      end
      want = hits_due.pop_front();
      if (tuser[0] !== want.found) begin
        $display("%0t: found expected %0b actual %0b", $realtime, want.found, tuser[0]);
        errors++;
      end
      if (tdata[5:0] !== want.hit) begin
        $display("%0t: hit_index expected %0d actual %0d", $realtime, want.hit, tdata[5:0]);
        errors++;
      end
      if (tuser[1] !== want.in_rect) begin
        $display("%0t: inside_res expected %0b actual %0b", $realtime, want.in_rect, tuser[1]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;

  hit_scoreboard sb = new();
  int src_idle_pct = 12;
  int dst_idle_pct = 67;
  bit hold_req = 1'b0;
  int quiet = 0;

  key_hit_test_nearest uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("key_hit_test_nearest regression: fail");
      $finish;
    end
  end

  function automatic logic [15:0] clip16(int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  function automatic logic [63:0] pack_beat(int idx, int x, int y, int w, int h);
    return {2'b00, 12'(h), 12'(w), clip16(y), clip16(x), 6'(idx)};
  endfunction

  task automatic send_beat(logic op, logic [63:0] data);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
    sb.note_beat(op, data);
  endtask

  task automatic query_at(int x, int y);
    send_beat(kht_pkg::OP_QUERY, pack_beat($urandom_range(63), x, y, $urandom_range(4095),
                                           $urandom_range(4095)));
  endtask

  // drop valid, drain every owed result, then let the scan finish off
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.hits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] value);
    wait_idle();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_NUM_KEYS) sb.num_keys = value[6:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(int items);
    int ox;
    int oy;
    int slot;
    int n;
    int sel;
    int px;
    int py;
    ox = int'($urandom_range(48000)) - 28000;
    oy = int'($urandom_range(48000)) - 28000;
    n = (sb.num_keys == 0) ? 1 :
        ((sb.num_keys < kht_pkg::MAX_KEYS_DEF) ? sb.num_keys : kht_pkg::MAX_KEYS_DEF);
    repeat (items) begin
      if ($urandom_range(99) < 25) begin
        slot = $urandom_range(63);
        if ($urandom_range(9) == 0) begin
          send_beat(kht_pkg::OP_WRITE, {2'b00, 12'($urandom), 12'($urandom), 16'($urandom),
                                        16'($urandom), 6'(slot)});
        end else begin
          send_beat(kht_pkg::OP_WRITE, pack_beat(slot, ox + int'($urandom_range(8000)),
                                                 oy + int'($urandom_range(8000)),
                                                 $urandom_range(10, 400),
                                                 $urandom_range(10, 400)));
        end
      end else begin
        sel = $urandom_range(99);
        slot = $urandom_range(n - 1);
        if (sel < 55) begin
          // around one scanned key, edges and just outside
          px = int'(sb.keys[slot].x) + int'($urandom_range(int'(sb.keys[slot].w) + 100)) - 50;
          py = int'(sb.keys[slot].y) + int'($urandom_range(int'(sb.keys[slot].h) + 100)) - 50;
        end else if (sel < 85) begin
          px = ox + int'($urandom_range(16000)) - 4000;
          py = oy + int'($urandom_range(16000)) - 4000;
        end else begin
          px = int'($urandom_range(65535)) - 32768;
          py = int'($urandom_range(65535)) - 32768;
        end
        query_at(px, py);
      end
    end
  endtask

  initial begin
    int counts [6];
    int ox;
    int oy;
    counts = '{64, 1, 127, 37, 65, 64};
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = kht_pkg::OP_WRITE;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty scan right after reset
    query_at(-32768, 32767);
    send_beat(kht_pkg::OP_WRITE, pack_beat(0, -32768, -32768, 4095, 4095));
    send_beat(kht_pkg::OP_WRITE, pack_beat(1, 32000, 32000, 4095, 4095));
    send_beat(kht_pkg::OP_WRITE, pack_beat(2, 100, 200, 0, 0));
    send_beat(kht_pkg::OP_WRITE, pack_beat(3, 98, 198, 4, 4));
    apb_write(ADDR_SPARE, 32'd9);
    query_at(100, 200);
    apb_write(ADDR_NUM_KEYS, 32'd4);
    query_at(100, 200);
    query_at(99, 199);
    send_beat(kht_pkg::OP_QUERY, pack_beat(63, 100, 200, 4095, 4095));
    query_at(-32768, -32768);
    query_at(-28673, -28673);
    query_at(-28672, -32768);
    query_at(32767, 32767);
    // squared distance exactly at the limit, then one pixel closer
    query_at(3100, 4200);
    query_at(3099, 4200);
    // equal centers, lowest index wins
    query_at(-5, 200);
    query_at(32767, -32768);
    query_at(-32768, 32767);
    apb_write(ADDR_NUM_KEYS, 32'd0);
    query_at(100, 200);

    ox = int'($urandom_range(48000)) - 28000;
    oy = int'($urandom_range(48000)) - 28000;
    for (int i = 0; i < kht_pkg::MAX_KEYS_DEF; i++) begin
      send_beat(kht_pkg::OP_WRITE, pack_beat(i, ox + int'($urandom_range(8000)),
                                             oy + int'($urandom_range(8000)),
                                             $urandom_range(4095), $urandom_range(4095)));
    end

    for (int p = 0; p < 6; p++) begin
      apb_write(ADDR_NUM_KEYS, 32'(counts[p]));
      if (p < 2) begin
        src_idle_pct = 12;
        dst_idle_pct = 67;
      end else if (p < 4) begin
        src_idle_pct = 67;
        dst_idle_pct = 12;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      if (p == 4) hold_req = 1'b1;
      run_phase(PHASE_ITEMS);
    end

    wait_idle();
    if (sb.errors == 0 && sb.hits_due.size() == 0) begin
      $display("key_hit_test_nearest regression: pass");
    end else begin
      $display("key_hit_test_nearest regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/kht_pkg.sv
rtl/kht_table.sv
rtl/kht_scan.sv
rtl/key_hit_test_nearest.sv
rtl/kht_checker.sv
tb/sv/key_hit_test_nearest_test.sv
